FILE: hdl/transposition_table_store_probe_core_assert.svh
// assertion macros for the transposition table store and probe core
`ifndef TRANSPOSITION_TABLE_STORE_PROBE_CORE_ASSERT_SVH
`define TRANSPOSITION_TABLE_STORE_PROBE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TTSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TTSP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TTSP_ASSERT(lbl, prop, msg)
`define TTSP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: hdl/ttsp_pkg.sv
// shared types and constants for the transposition table store and probe core
package ttsp_pkg;

  localparam int unsigned HASH_W          = 64;
  localparam int unsigned SCORE_W         = 32;
  localparam int unsigned DEPTH_W         = 8;
  localparam int unsigned MOVE_W          = 22;
  localparam int unsigned DEFAULT_ENTRIES = 65536;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_PROBE = 1'b1;

  typedef enum logic [1:0] {
    TYPE_INVALID = 2'd0,
    TYPE_EXACT   = 2'd1,
    TYPE_LOWER   = 2'd2,
    TYPE_UPPER   = 2'd3
  } entry_type_e;

  typedef struct packed {
    logic [HASH_W-1:0]         hash;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [MOVE_W-1:0]         move;
    entry_type_e               etype;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clear_we;
    logic accept;
    logic eval_fire;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hdl/ttsp_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module ttsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/ttsp_ctrl.sv
// controller state machine: clearing pass, accept and evaluate sequencing
module ttsp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ttsp_pkg::dp_status_t  status_i,
  output ttsp_pkg::ctrl_cmd_t   cmd_o
);
  import ttsp_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EVAL  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_we = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status_i.out_free) begin
          cmd_o.eval_fire = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/ttsp_datapath.sv
// datapath: entry memory, request capture, store decision and result register
module ttsp_datapath #(
  parameter int unsigned TABLE_ENTRIES = ttsp_pkg::DEFAULT_ENTRIES
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ttsp_pkg::ctrl_cmd_t                   cmd_i,
  output ttsp_pkg::dp_status_t                  status_o,
  input  logic                                  func_i,
  input  logic [ttsp_pkg::HASH_W-1:0]           position_hash_i,
  input  logic [ttsp_pkg::DEPTH_W-1:0]          search_depth_i,
  input  logic signed [ttsp_pkg::SCORE_W-1:0]   window_alpha_i,
  input  logic signed [ttsp_pkg::SCORE_W-1:0]   window_beta_i,
  input  logic signed [ttsp_pkg::SCORE_W-1:0]   result_score_i,
  input  logic [ttsp_pkg::MOVE_W-1:0]           best_move_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            entry_type_o,
  output logic signed [ttsp_pkg::SCORE_W-1:0]   entry_score_o,
  output logic [ttsp_pkg::DEPTH_W-1:0]          entry_depth_o,
  output logic [ttsp_pkg::MOVE_W-1:0]           entry_move_o,
  output logic                                  was_written_o
);
  import ttsp_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  logic [IDX_W-1:0]         clr_cnt_q, clr_cnt_d;
  logic                     func_q;
  logic [HASH_W-1:0]        hash_q;
  logic [DEPTH_W-1:0]       depth_q;
  logic signed [SCORE_W-1:0] alpha_q, beta_q, score_q;
  logic [MOVE_W-1:0]        move_q;

  logic [ENTRY_W-1:0]       rdata;
  entry_t                   cur;
  entry_t                   new_entry;
  entry_t                   res_entry;
  entry_type_e              new_type;
  logic                     keep;
  logic                     hit;

  entry_t                   out_q, out_d;
  logic                     written_q, written_d;
  logic                     out_valid_q, out_valid_d;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [ENTRY_W-1:0]       ram_wdata;

  // clearing pass counter
  assign clr_cnt_d = cmd_i.clear_we ? clr_cnt_q + 1'b1 : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q  <= func_i;
      hash_q  <= position_hash_i;
      depth_q <= search_depth_i;
      alpha_q <= window_alpha_i;
      beta_q  <= window_beta_i;
      score_q <= result_score_i;
      move_q  <= best_move_i;
    end
  end

  assign cur = entry_t'(rdata);

  always_comb begin
    if (score_q >= beta_q) begin
      new_type = TYPE_LOWER;
    end else if (score_q <= alpha_q) begin
      new_type = TYPE_UPPER;
    end else begin
      new_type = TYPE_EXACT;
    end
    new_entry.hash  = hash_q;
    new_entry.score = score_q;
    new_entry.depth = depth_q;
    new_entry.move  = move_q;
    new_entry.etype = new_type;

    hit  = (cur.hash == hash_q);
    keep = hit && (cur.depth >= depth_q) &&
           ((cur.etype == new_type) || (cur.etype == TYPE_EXACT));

    if (func_q == FUNC_PROBE) begin
      res_entry = cur;
      if (!hit) begin
        res_entry.etype = TYPE_INVALID;
      end
      written_d = 1'b0;
    end else begin
      res_entry = keep ? cur : new_entry;
      written_d = !keep;
    end
  end

  // memory write port: clearing pass or store update
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hash_q[IDX_W-1:0];
    ram_wdata = ENTRY_W'(new_entry);
    if (cmd_i.clear_we) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (cmd_i.eval_fire && (func_q == FUNC_STORE) && !keep) begin
      ram_we = 1'b1;
    end
  end

  ttsp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (position_hash_i[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (cmd_i.eval_fire) begin
      out_valid_d = 1'b1;
      out_d       = res_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_fire) begin
      out_q     <= out_d;
      written_q <= written_d;
    end
  end

  assign status_o.clear_last = (clr_cnt_q == {IDX_W{1'b1}});
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign entry_type_o  = out_q.etype;
  assign entry_score_o = out_q.score;
  assign entry_depth_o = out_q.depth;
  assign entry_move_o  = out_q.move;
  assign was_written_o = written_q;

endmodule

FILE: hdl/transposition_table_store_probe_core.sv
// top level of the transposition table store and probe core
// Direct-mapped table of search results, indexed by the low bits of the
// position hash (TABLE_ENTRIES is a power of two). One request in, one
// result out, both on valid/ready channels.
// A store request (func 0) classifies its score against the window and
// overwrites the indexed entry unless a deeper or equal entry of the same
// position already holds a compatible bound; the result is the entry as it
// stands afterwards, with was_written set when it was replaced.
// A probe request (func 1) returns the indexed entry, typed invalid on a
// hash mismatch.
// A request's entry is first read into the registered memory output and
// then evaluated into the result register with a read-modify-write of that
// entry; no new request is taken before that evaluation. Reset: the entry
// memory is cleared by a pass over all TABLE_ENTRIES entries (65536 by
// default), during which in_ready_o is low.
// A stalled receiver holds the result register; one further request is
// still taken and then waits until the result register is freed.
module transposition_table_store_probe_core #(
  parameter int unsigned TABLE_ENTRIES = ttsp_pkg::DEFAULT_ENTRIES
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  func_i,
  input  logic [ttsp_pkg::HASH_W-1:0]           position_hash_i,
  input  logic [ttsp_pkg::DEPTH_W-1:0]          search_depth_i,
  input  logic signed [ttsp_pkg::SCORE_W-1:0]   window_alpha_i,
  input  logic signed [ttsp_pkg::SCORE_W-1:0]   window_beta_i,
  input  logic signed [ttsp_pkg::SCORE_W-1:0]   result_score_i,
  input  logic [ttsp_pkg::MOVE_W-1:0]           best_move_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            entry_type_o,
  output logic signed [ttsp_pkg::SCORE_W-1:0]   entry_score_o,
  output logic [ttsp_pkg::DEPTH_W-1:0]          entry_depth_o,
  output logic [ttsp_pkg::MOVE_W-1:0]           entry_move_o,
  output logic                                  was_written_o
);
  import ttsp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ttsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ttsp_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .func_i          (func_i),
    .position_hash_i (position_hash_i),
    .search_depth_i  (search_depth_i),
    .window_alpha_i  (window_alpha_i),
    .window_beta_i   (window_beta_i),
    .result_score_i  (result_score_i),
    .best_move_i     (best_move_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .entry_type_o    (entry_type_o),
    .entry_score_o   (entry_score_o),
    .entry_depth_o   (entry_depth_o),
    .entry_move_o    (entry_move_o),
    .was_written_o   (was_written_o)
  );

`include "transposition_table_store_probe_core_assert.svh"

  `TTSP_ASSERT_RST(a_no_accept_in_reset, !rst_ni |-> !in_ready_o, "request taken in reset")
  `TTSP_ASSERT(a_no_accept_while_clear, cmd.clear_we |-> !in_ready_o, "request during clear")
  `TTSP_ASSERT(a_accept_then_busy, cmd.accept |=> !in_ready_o, "second request before eval")
  `TTSP_ASSERT(a_eval_gives_result, cmd.eval_fire |=> out_valid_o, "evaluated result lost")

endmodule
